FILE: rtl/threshold_segment_detector_assert.svh
// Assertion macros for the threshold segment detector.
// Used by the top level; expects clk and rst in scope.
`ifndef THRESHOLD_SEGMENT_DETECTOR_ASSERT_SVH
`define THRESHOLD_SEGMENT_DETECTOR_ASSERT_SVH

// same-cycle implication
`define TSD_CHECK_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TSD_CHECK_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/tsd_pkg.sv
// Shared types, constants and helper functions for the threshold segment detector.
// No dependencies.
package tsd_pkg;

  localparam int TSD_RUN_DEPTH = 128;

  localparam int SAMPLE_W = 16;
  localparam int PCT_W    = 7;
  localparam int WORD_W   = 32;
  localparam int NUM_W    = 16;
  localparam int THR_W    = 24;
  localparam int PROD_W   = 2 * WORD_W;
  localparam int ADDR_W   = 4;
  localparam int TDATA_W  = 2 * WORD_W + NUM_W;

  localparam logic [SAMPLE_W-1:0] ABS_LIMIT_RST = '0;
  localparam logic [PCT_W-1:0]    PCT_ABS_MODE  = 7'd100;
  localparam logic [WORD_W-1:0]   SCALE_RST     = 32'h0001_0000;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX    = 16'hFFFF;
  localparam logic [NUM_W-1:0]    NUM_MAX       = 16'hFFFF;

  typedef enum logic [1:0] {
    REG_ABS_LIMIT = 2'd0,
    REG_REL_PCT   = 2'd1,
    REG_SCALE     = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] abs_limit;
    logic [PCT_W-1:0]    relative_percent;
    logic [WORD_W-1:0]   scale_factor;
  } cfg_t;

  // 100 * x by shift and add
  function automatic logic [THR_W-1:0] times100(input logic [SAMPLE_W-1:0] x);
    logic [THR_W-1:0] xe;
    xe = THR_W'(x);
    return (xe << 6) + (xe << 5) + (xe << 2);
  endfunction

  // Q16.16 product back to an integer, saturating
  function automatic logic [WORD_W-1:0] sat_scale(input logic [PROD_W-1:0] p);
    logic [WORD_W-1:0] r;
    if (p[PROD_W-1:WORD_W+16] != '0) r = '1;
    else r = p[WORD_W+15:16];
    return r;
  endfunction

endpackage

FILE: rtl/tsd_regs.sv
// Configuration register file with an APB-style slave port.
// Depends on tsd_pkg.
module tsd_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tsd_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output tsd_pkg::cfg_t              cfg
);
  import tsd_pkg::*;

  logic     wr;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite & pready;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.abs_limit        <= ABS_LIMIT_RST;
      cfg.relative_percent <= PCT_ABS_MODE;
      cfg.scale_factor     <= SCALE_RST;
    end else if (wr) begin
      case (idx)
        REG_ABS_LIMIT: cfg.abs_limit        <= pwdata[SAMPLE_W-1:0];
        REG_REL_PCT:   cfg.relative_percent <= pwdata[PCT_W-1:0];
        REG_SCALE:     cfg.scale_factor     <= pwdata[WORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ABS_LIMIT: prdata = 32'(cfg.abs_limit);
      REG_REL_PCT:   prdata = 32'(cfg.relative_percent);
      REG_SCALE:     prdata = cfg.scale_factor;
      default:       prdata = '0;
    endcase
  end

endmodule

FILE: rtl/tsd_mul.sv
// Shared 32x32 multiplier with registered 64-bit product.
// Depends on tsd_pkg.
module tsd_mul (
  input  logic                       clk,
  input  logic [tsd_pkg::WORD_W-1:0] op_a,
  input  logic [tsd_pkg::WORD_W-1:0] op_b,
  output logic [tsd_pkg::PROD_W-1:0] prod
);
  import tsd_pkg::*;

  always_ff @(posedge clk) begin
    prod <= PROD_W'(op_a) * PROD_W'(op_b);
  end

endmodule

FILE: rtl/threshold_segment_detector.sv
// Threshold segment detector: finds runs of samples above abs_limit and reports each run
// (or, in relative mode, each sub-run above min+(max-min)*pct/100) as one output word with
// scaled offset, scaled length and a segment number. Samples that do not end a run are
// taken one per cycle, back to back. A sample that ends a run holds s_tready low while the
// sequencer works: in absolute mode or on buffer overflow it scales and sends the run's
// word; in relative mode it computes the threshold, rereads each buffered sample and scales
// and sends each sub-run; an output stall holds it longer. The threshold product and the
// Q16.16 scaling go through one shared 32x32 multiplier; the run buffer is a
// RUN_DEPTH-entry memory read one entry per rescan step. No clearing pass after reset.
// Depends on tsd_pkg, tsd_regs, tsd_mul and threshold_segment_detector_assert.svh.
`include "threshold_segment_detector_assert.svh"

module threshold_segment_detector #(
  parameter int RUN_DEPTH = tsd_pkg::TSD_RUN_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  // APB config
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tsd_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  // sample stream
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [15:0]                 s_tdata,  // [15:0] sample_value
  input  logic                        s_tlast,  // is_final
  // segment stream
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [tsd_pkg::TDATA_W-1:0] m_tdata,  // [31:0] seg_offset, [63:32] seg_length,
                                                // [79:64] seg_number
  output logic                        m_tlast,  // run_end
  output logic                        m_tuser   // overflow
);
  import tsd_pkg::*;

  localparam int AW = $clog2(RUN_DEPTH);

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_THR  = 9'b000000010,
    ST_THRW = 9'b000000100,
    ST_RD   = 9'b000001000,
    ST_CMP  = 9'b000010000,
    ST_MULO = 9'b000100000,
    ST_MULL = 9'b001000000,
    ST_XFER = 9'b010000000,
    ST_DONE = 9'b100000000
  } state_t;

  cfg_t   cfg;
  state_t state;

  logic [WORD_W-1:0]   sample_index;
  logic [WORD_W-1:0]   run_start;
  logic [WORD_W-1:0]   run_count;
  logic                in_run;
  logic [SAMPLE_W-1:0] run_min;
  logic [SAMPLE_W-1:0] run_max;
  logic [NUM_W-1:0]    seg_total;
  logic                fin_pend;
  logic                scanning;
  logic                scan_open;
  logic [AW-1:0]       p;
  logic [AW-1:0]       scan_len;
  logic [AW-1:0]       cnt;
  logic [WORD_W-1:0]   scan_base;
  logic [THR_W-1:0]    thr;
  logic [WORD_W-1:0]   em_off;
  logic [WORD_W-1:0]   em_len;
  logic                em_ovf;
  logic [WORD_W-1:0]   new_off;
  logic [WORD_W-1:0]   hold_off;
  logic [WORD_W-1:0]   hold_len;
  logic [NUM_W-1:0]    hold_num;
  logic                hold_ovf;
  logic                hold_valid;

  logic [SAMPLE_W-1:0] mem [RUN_DEPTH];
  logic [SAMPLE_W-1:0] mem_q;

  logic                accept;
  logic [SAMPLE_W-1:0] v;
  logic [WORD_W-1:0]   pos;
  logic                pos_fits;
  logic                run_ends;
  logic                out_free;
  logic                push;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [THR_W-1:0]    a100;
  logic                a_lt;
  logic                a_gt;
  logic [NUM_W-1:0]    seg_next;
  logic [WORD_W-1:0]   mul_a;
  logic [WORD_W-1:0]   mul_b;
  logic [PROD_W-1:0]   mul_p;

  tsd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tsd_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (mul_p)
  );

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid & s_tready;
  assign v        = s_tdata[SAMPLE_W-1:0];
  assign pos      = sample_index - run_start;
  assign pos_fits = pos < WORD_W'(RUN_DEPTH);
  assign run_ends = (v < cfg.abs_limit) | s_tlast;
  assign out_free = ~m_tvalid | m_tready;
  assign push     = hold_valid & out_free & ((state == ST_XFER) | (state == ST_DONE));
  assign a100     = times100(mem_q);
  assign a_lt     = a100 < thr;
  assign a_gt     = a100 > thr;
  assign seg_next = (seg_total == NUM_MAX) ? seg_total : seg_total + 1'b1;

  assign wr_en   = accept & (in_run ? pos_fits : (v > cfg.abs_limit));
  assign wr_addr = in_run ? pos[AW-1:0] : '0;

  always_comb begin
    mul_b = cfg.scale_factor;
    mul_a = em_len;
    case (state)
      ST_THR: begin
        mul_a = WORD_W'(run_max - run_min);
        mul_b = WORD_W'(cfg.relative_percent);
      end
      ST_MULO: mul_a = em_off;
      default: ;
    endcase
  end

  // run buffer
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= v;
    if (state == ST_RD) mem_q <= mem[p];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (push) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      sample_index <= '0;
      run_start    <= '0;
      run_count    <= '0;
      in_run       <= 1'b0;
      run_min      <= SAMPLE_MAX;
      run_max      <= '0;
      seg_total    <= '0;
      fin_pend     <= 1'b0;
      scanning     <= 1'b0;
      scan_open    <= 1'b0;
      hold_valid   <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (in_run) begin
              if (v < run_min) run_min <= v;
              if (v > run_max) run_max <= v;
              if (run_ends) begin
                in_run       <= 1'b0;
                fin_pend     <= s_tlast;
                sample_index <= sample_index + 1'b1;
                em_off       <= run_start;
                em_len       <= run_count;
                if (cfg.relative_percent == PCT_ABS_MODE || !pos_fits) begin
                  em_ovf   <= (cfg.relative_percent != PCT_ABS_MODE);
                  scanning <= 1'b0;
                  state    <= ST_MULO;
                end else begin
                  scan_len  <= pos[AW-1:0];
                  scan_base <= run_start;
                  p         <= '0;
                  cnt       <= '0;
                  scan_open <= 1'b0;
                  scanning  <= 1'b1;
                  state     <= ST_THR;
                end
              end else begin
                if (v > cfg.abs_limit) run_count <= run_count + 1'b1;
                sample_index <= sample_index + 1'b1;
              end
            end else if (s_tlast) begin
              sample_index <= '0;
              run_start    <= '0;
              run_count    <= '0;
              run_min      <= SAMPLE_MAX;
              run_max      <= '0;
              seg_total    <= '0;
            end else begin
              sample_index <= sample_index + 1'b1;
              if (v > cfg.abs_limit) begin
                in_run    <= 1'b1;
                run_start <= sample_index;
                run_count <= '0;
                run_min   <= v;
                run_max   <= v;
              end
            end
          end
        end
        ST_THR: state <= ST_THRW;
        ST_THRW: begin
          thr   <= times100(run_min) + mul_p[THR_W-1:0];
          state <= ST_RD;
        end
        ST_RD: begin
          if (p == scan_len) begin
            scanning <= 1'b0;
            if (scan_open) begin
              em_len    <= WORD_W'(cnt);
              em_ovf    <= 1'b0;
              scan_open <= 1'b0;
              state     <= ST_MULO;
            end else begin
              state <= ST_DONE;
            end
          end else begin
            state <= ST_CMP;
          end
        end
        ST_CMP: begin
          p <= p + 1'b1;
          if (scan_open) begin
            if (a_lt) begin
              em_len    <= WORD_W'(cnt);
              em_ovf    <= 1'b0;
              scan_open <= 1'b0;
              state     <= ST_MULO;
            end else begin
              if (a_gt) cnt <= cnt + 1'b1;
              state <= ST_RD;
            end
          end else begin
            if (a_gt) begin
              scan_open <= 1'b1;
              em_off    <= scan_base + WORD_W'(p);
              cnt       <= '0;
            end
            state <= ST_RD;
          end
        end
        ST_MULO: state <= ST_MULL;
        ST_MULL: begin
          new_off <= sat_scale(mul_p);
          state   <= ST_XFER;
        end
        ST_XFER: begin
          if (!hold_valid || out_free) begin
            if (hold_valid) begin
              m_tdata  <= {hold_num, hold_len, hold_off};
              m_tlast  <= 1'b0;
              m_tuser  <= hold_ovf;
            end
            hold_off   <= new_off;
            hold_len   <= sat_scale(mul_p);
            hold_num   <= seg_next;
            hold_ovf   <= em_ovf;
            hold_valid <= 1'b1;
            seg_total  <= seg_next;
            state      <= scanning ? ST_RD : ST_DONE;
          end
        end
        ST_DONE: begin
          if (!hold_valid || out_free) begin
            if (hold_valid) begin
              m_tdata  <= {hold_num, hold_len, hold_off};
              m_tlast  <= 1'b1;
              m_tuser  <= hold_ovf;
            end
            hold_valid <= 1'b0;
            if (fin_pend) begin
              sample_index <= '0;
              run_start    <= '0;
              run_count    <= '0;
              run_min      <= SAMPLE_MAX;
              run_max      <= '0;
              seg_total    <= '0;
            end
            fin_pend <= 1'b0;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `TSD_CHECK_IMP(a_no_held_word_idle, hold_valid, state != ST_IDLE, "result word held in idle")
  `TSD_CHECK_IMP(a_cmp_in_range, state == ST_CMP, p < scan_len, "rescan past end of run")
  `TSD_CHECK_IMP(a_held_numbered, hold_valid, seg_total != '0, "held word without number")
  `TSD_CHECK_NXT(a_push_on_xfer, (state == ST_XFER) && hold_valid && out_free,
                 m_tvalid && !m_tlast, "pending word not pushed")

endmodule
